>>> rtl/iir_bandpass_cascade_macros.svh
// assertion macros for the band-pass cascade
// used by the top level of the block, no other dependencies
`ifndef IIR_BANDPASS_CASCADE_MACROS_SVH
`define IIR_BANDPASS_CASCADE_MACROS_SVH

// check a property on every rising edge, idle while reset is high
`define IIRBP_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// check a property on every rising edge, reset included
`define IIRBP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/iirbp_pkg.sv
// shared types, constants and coefficient tables of the band-pass cascade
// no dependencies; coefficients are turned into fixed point at elaboration
package iirbp_pkg;

   localparam int MAX_TAPS            = 16;
   localparam int TAP_W               = $clog2(MAX_TAPS);
   localparam int DEF_HP_TAPS         = 6;
   localparam int DEF_LP_TAPS         = 7;
   localparam int DEF_COEF_FRAC_BITS  = 58;
   localparam int DEF_STATE_FRAC_BITS = 40;
   localparam int SAMPLE_W            = 16;
   localparam int WORD_W              = 64;
   localparam int ACC_W               = 128;

   // partial product selector of the shared multiplier
   localparam logic [1:0] PART_LO_LO = 2'd0;
   localparam logic [1:0] PART_LO_HI = 2'd1;
   localparam logic [1:0] PART_HI_LO = 2'd2;
   localparam logic [1:0] PART_HI_HI = 2'd3;

   // decimal coefficient: (neg ? -1 : 1) * mant * 10^-dexp
   typedef struct packed {
      logic        neg;
      logic [63:0] mant;
      logic [4:0]  dexp;
   } dcoef_type;

   typedef dcoef_type        dcoef_tab_type [MAX_TAPS];
   typedef logic [63:0]      coef_tab_type  [MAX_TAPS];

   // control from the sequencer to the multiply-accumulate unit
   typedef struct packed {
      logic       clear;
      logic       issue;
      logic       sub;
      logic [1:0] part;
   } mac_ctrl_type;

   localparam dcoef_type DZERO = '{neg: 1'b0, mant: 64'd0, dexp: 5'd0};

   localparam dcoef_tab_type HP_B_DEC = '{
      0: '{1'b0, 64'd9936059630099, 5'd13},
      1: '{1'b1, 64'd496802981505,  5'd11},
      2: '{1'b0, 64'd9936059630099, 5'd12},
      3: '{1'b1, 64'd9936059630099, 5'd12},
      4: '{1'b0, 64'd496802981505,  5'd11},
      5: '{1'b1, 64'd9936059630099, 5'd13},
      default: DZERO};

   localparam dcoef_tab_type HP_A_DEC = '{
      0: '{1'b0, 64'd1,             5'd0},
      1: '{1'b1, 64'd4987170880032, 5'd12},
      2: '{1'b0, 64'd994876577478,  5'd11},
      3: '{1'b1, 64'd9923271718397, 5'd12},
      4: '{1'b0, 64'd4948929633379, 5'd12},
      5: '{1'b1, 64'd9872528097289, 5'd13},
      default: DZERO};

   localparam dcoef_tab_type LP_B_DEC = '{
      0: '{1'b0, 64'd6594578622361, 5'd23},
      1: '{1'b0, 64'd3956747173417, 5'd22},
      2: '{1'b0, 64'd9891867933541, 5'd22},
      3: '{1'b0, 64'd1318915724472, 5'd21},
      4: '{1'b0, 64'd9891867933541, 5'd22},
      5: '{1'b0, 64'd3956747173417, 5'd22},
      6: '{1'b0, 64'd6594578622361, 5'd23},
      default: DZERO};

   localparam dcoef_tab_type LP_A_DEC = '{
      0: '{1'b0, 64'd1,             5'd0},
      1: '{1'b1, 64'd5842652126594, 5'd12},
      2: '{1'b0, 64'd1422559205773, 5'd11},
      3: '{1'b1, 64'd1847523699553, 5'd11},
      4: '{1'b0, 64'd1349869991173, 5'd11},
      5: '{1'b1, 64'd5260796021795, 5'd12},
      6: '{1'b0, 64'd8543931786795, 5'd13},
      default: DZERO};

   // round-half-up of |c| * 2^frac, saturated, sign applied last
   function automatic logic [63:0] coef_word(input dcoef_type c, input int frac);
      logic [127:0] v;
      logic [63:0]  mag;
      v = 128'(c.mant) << (frac + 1);
      for (int i = 0; i < 32; i++) begin
         if (i < int'(c.dexp)) begin
            v = v / 128'd10;
         end
      end
      v   = v + 128'd1;
      v   = v >> 1;
      mag = (v[127:63] != '0) ? 64'h7FFF_FFFF_FFFF_FFFF : v[63:0];
      return c.neg ? (64'd0 - mag) : mag;
   endfunction

   function automatic coef_tab_type coef_tab(input dcoef_tab_type d, input int frac);
      coef_tab_type t;
      for (int k = 0; k < MAX_TAPS; k++) begin
         t[k] = coef_word(d[k], frac);
      end
      return t;
   endfunction

endpackage

>>> rtl/iir_bandpass_cascade.sv
// One sample at a time: req_tready is high only while the sequencer is idle, so a new
// req transaction is taken only after the previous result has entered the output register.
// The pace is set by the single shared 33x33 multiplier: four partials per 64x64 term,
// one term per coefficient, plus a drain step and a finish step per section.
// Reset (synchronous, active high) clears all filter histories to zero and empties the
// output register; req_tready is high from reset on, as the sequencer starts idle.
module iir_bandpass_cascade #(
   parameter int HP_TAPS         = iirbp_pkg::DEF_HP_TAPS,
   parameter int LP_TAPS         = iirbp_pkg::DEF_LP_TAPS,
   parameter int COEF_FRAC_BITS  = iirbp_pkg::DEF_COEF_FRAC_BITS,
   parameter int STATE_FRAC_BITS = iirbp_pkg::DEF_STATE_FRAC_BITS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] sample_in
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata    // [15:0] sample_out
);
   import iirbp_pkg::*;
   `include "iir_bandpass_cascade_macros.svh"

   localparam int IO_SHIFT = STATE_FRAC_BITS - 15;
   localparam int HXW      = (HP_TAPS > 1) ? $clog2(HP_TAPS) : 1;
   localparam int HYW      = (HP_TAPS > 2) ? $clog2(HP_TAPS - 1) : 1;
   localparam int LXW      = (LP_TAPS > 1) ? $clog2(LP_TAPS) : 1;
   localparam int LYW      = (LP_TAPS > 2) ? $clog2(LP_TAPS - 1) : 1;
   localparam int ACC_HI_W = ACC_W - (COEF_FRAC_BITS + 63);
   localparam int OUT_HI_W = WORD_W - STATE_FRAC_BITS;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_RUN   = 4'b0010,
      ST_DRAIN = 4'b0100,
      ST_FIN   = 4'b1000
   } state_type;

   state_type          state_in, state_ff;
   logic               stage_in, stage_ff;
   logic               side_in, side_ff;
   logic [TAP_W-1:0]   tap_in, tap_ff;
   logic [1:0]         part_in, part_ff;
   logic [63:0]        hp_xh_in [HP_TAPS];
   logic [63:0]        hp_xh_ff [HP_TAPS];
   logic [63:0]        hp_yh_in [HP_TAPS-1];
   logic [63:0]        hp_yh_ff [HP_TAPS-1];
   logic [63:0]        lp_xh_in [LP_TAPS];
   logic [63:0]        lp_xh_ff [LP_TAPS];
   logic [63:0]        lp_yh_in [LP_TAPS-1];
   logic [63:0]        lp_yh_ff [LP_TAPS-1];
   logic               rsp_tvalid_in, rsp_tvalid_ff;
   logic [15:0]        rsp_tdata_in, rsp_tdata_ff;

   mac_ctrl_type       mac_ctrl;
   logic [63:0]        coef;
   logic [63:0]        hist_word;
   logic [127:0]       acc;
   logic [TAP_W-1:0]   tap_m1;
   logic               tap_last;
   logic [63:0]        x_scaled;
   logic [ACC_HI_W-1:0] acc_hi;
   logic [63:0]        stage_y;
   logic [OUT_HI_W-1:0] y_hi;
   logic [15:0]        out_word;

   // shared units
   iirbp_coef #(
      .COEF_FRAC_BITS(COEF_FRAC_BITS)
   ) u_coef (
      .stage_i (stage_ff),
      .side_i  (side_ff),
      .tap_i   (tap_ff),
      .coef_o  (coef)
   );

   iirbp_mac u_mac (
      .clock  (clock),
      .reset  (reset),
      .ctrl_i (mac_ctrl),
      .coef_i (coef),
      .data_i (hist_word),
      .acc_o  (acc)
   );

   // history operand: input history on the feed-forward side, output history otherwise
   always_comb begin
      tap_m1   = tap_ff - TAP_W'(1);
      tap_last = (tap_ff == TAP_W'((stage_ff ? LP_TAPS : HP_TAPS) - 1));
      case ({stage_ff, side_ff})
         2'b00:   hist_word = hp_xh_ff[tap_ff[HXW-1:0]];
         2'b01:   hist_word = hp_yh_ff[tap_m1[HYW-1:0]];
         2'b10:   hist_word = lp_xh_ff[tap_ff[LXW-1:0]];
         2'b11:   hist_word = lp_yh_ff[tap_m1[LYW-1:0]];
         default: hist_word = '0;
      endcase
   end

   // input scaling, section result and output saturation
   always_comb begin
      x_scaled = {{(WORD_W - SAMPLE_W - IO_SHIFT){req_tdata[15]}}, req_tdata,
                  {IO_SHIFT{1'b0}}};
      acc_hi   = acc[ACC_W-1 -: ACC_HI_W];
      if (acc_hi == '0 || acc_hi == '1) begin
         stage_y = acc[COEF_FRAC_BITS+63:COEF_FRAC_BITS];
      end else begin
         stage_y = acc[ACC_W-1] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
      end
      y_hi = stage_y[WORD_W-1 -: OUT_HI_W];
      if (y_hi == '0 || y_hi == '1) begin
         out_word = stage_y[STATE_FRAC_BITS:IO_SHIFT];
      end else begin
         out_word = stage_y[63] ? 16'h8000 : 16'h7FFF;
      end
   end

   // sequencer and history updates
   always_comb begin
      state_in      = state_ff;
      stage_in      = stage_ff;
      side_in       = side_ff;
      tap_in        = tap_ff;
      part_in       = part_ff;
      hp_xh_in      = hp_xh_ff;
      hp_yh_in      = hp_yh_ff;
      lp_xh_in      = lp_xh_ff;
      lp_yh_in      = lp_yh_ff;
      rsp_tvalid_in = rsp_tvalid_ff & ~rsp_tready;
      rsp_tdata_in  = rsp_tdata_ff;
      mac_ctrl      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               for (int k = HP_TAPS - 1; k > 0; k--) begin
                  hp_xh_in[k] = hp_xh_ff[k-1];
               end
               hp_xh_in[0]    = x_scaled;
               stage_in       = 1'b0;
               side_in        = 1'b0;
               tap_in         = '0;
               part_in        = PART_LO_LO;
               mac_ctrl.clear = 1'b1;
               state_in       = ST_RUN;
            end
         end
         ST_RUN: begin
            mac_ctrl.issue = 1'b1;
            mac_ctrl.sub   = side_ff;
            mac_ctrl.part  = part_ff;
            part_in        = part_ff + 2'd1;
            if (part_ff == PART_HI_HI) begin
               if (tap_last) begin
                  if (side_ff) begin
                     state_in = ST_DRAIN;
                  end else begin
                     side_in = 1'b1;
                     tap_in  = TAP_W'(1);
                  end
               end else begin
                  tap_in = tap_ff + TAP_W'(1);
               end
            end
         end
         ST_DRAIN: begin
            state_in = ST_FIN;
         end
         ST_FIN: begin
            if (!stage_ff) begin
               // high-pass done: record its output and feed the low-pass
               for (int k = HP_TAPS - 2; k > 0; k--) begin
                  hp_yh_in[k] = hp_yh_ff[k-1];
               end
               hp_yh_in[0] = stage_y;
               for (int k = LP_TAPS - 1; k > 0; k--) begin
                  lp_xh_in[k] = lp_xh_ff[k-1];
               end
               lp_xh_in[0]    = stage_y;
               stage_in       = 1'b1;
               side_in        = 1'b0;
               tap_in         = '0;
               part_in        = PART_LO_LO;
               mac_ctrl.clear = 1'b1;
               state_in       = ST_RUN;
            end else if (!rsp_tvalid_ff || rsp_tready) begin
               // low-pass done: record its output and hand over the result
               for (int k = LP_TAPS - 2; k > 0; k--) begin
                  lp_yh_in[k] = lp_yh_ff[k-1];
               end
               lp_yh_in[0]   = stage_y;
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = out_word;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control and history registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         stage_ff      <= 1'b0;
         side_ff       <= 1'b0;
         tap_ff        <= '0;
         part_ff       <= PART_LO_LO;
         rsp_tvalid_ff <= 1'b0;
         hp_xh_ff      <= '{default: '0};
         hp_yh_ff      <= '{default: '0};
         lp_xh_ff      <= '{default: '0};
         lp_yh_ff      <= '{default: '0};
      end else begin
         state_ff      <= state_in;
         stage_ff      <= stage_in;
         side_ff       <= side_in;
         tap_ff        <= tap_in;
         part_ff       <= part_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
         hp_xh_ff      <= hp_xh_in;
         hp_yh_ff      <= hp_yh_in;
         lp_xh_ff      <= lp_xh_in;
         lp_yh_ff      <= lp_yh_in;
      end
   end

   // output payload register
   always_ff @(posedge clock) begin
      rsp_tdata_ff <= rsp_tdata_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   // an accepted transaction starts the high-pass section
   `IIRBP_ASSERT(a_accept_starts_hp, clock, reset, (req_tvalid && req_tready) |=> (state_ff == ST_RUN && !stage_ff && tap_ff == '0), "accepted transaction did not start the high-pass section")
   // a new result only comes out of the low-pass finish step
   `IIRBP_ASSERT(a_result_from_lp, clock, reset, $rose(rsp_tvalid) |-> $past(state_ff == ST_FIN && stage_ff), "result appeared outside the low-pass finish step")
   // the last feedback partial is followed by the drain cycle
   `IIRBP_ASSERT(a_last_term_drains, clock, reset, (state_ff == ST_RUN && side_ff && tap_last && part_ff == PART_HI_HI) |=> (state_ff == ST_DRAIN), "last term did not lead to drain")
   // a full output register holds the low-pass finish step
   `IIRBP_ASSERT(a_finish_waits, clock, reset, (state_ff == ST_FIN && stage_ff && rsp_tvalid && !rsp_tready) |=> (state_ff == ST_FIN && $stable(rsp_tdata)), "finish step overran a waiting result")

endmodule

>>> rtl/iirbp_coef.sv
// coefficient lookup for both filter sections
// depends on iirbp_pkg for the decimal tables and the conversion function
module iirbp_coef #(
   parameter int COEF_FRAC_BITS = iirbp_pkg::DEF_COEF_FRAC_BITS
) (
   input  logic                       stage_i,   // 0 high-pass, 1 low-pass
   input  logic                       side_i,    // 0 feed-forward, 1 feedback
   input  logic [iirbp_pkg::TAP_W-1:0] tap_i,
   output logic [63:0]                coef_o
);
   import iirbp_pkg::*;

   localparam coef_tab_type HP_B = coef_tab(HP_B_DEC, COEF_FRAC_BITS);
   localparam coef_tab_type HP_A = coef_tab(HP_A_DEC, COEF_FRAC_BITS);
   localparam coef_tab_type LP_B = coef_tab(LP_B_DEC, COEF_FRAC_BITS);
   localparam coef_tab_type LP_A = coef_tab(LP_A_DEC, COEF_FRAC_BITS);

   // pick the table for the current section and side
   always_comb begin
      case ({stage_i, side_i})
         2'b00:   coef_o = HP_B[tap_i];
         2'b01:   coef_o = HP_A[tap_i];
         2'b10:   coef_o = LP_B[tap_i];
         2'b11:   coef_o = LP_A[tap_i];
         default: coef_o = '0;
      endcase
   end

endmodule

>>> rtl/iirbp_mac.sv
// shared multiply-accumulate unit: one signed 33x33 partial product a cycle
// four partials build an exact 64x64 product in a 128-bit accumulator; uses iirbp_pkg
module iirbp_mac (
   input  logic                    clock,
   input  logic                    reset,
   input  iirbp_pkg::mac_ctrl_type ctrl_i,
   input  logic [63:0]             coef_i,
   input  logic [63:0]             data_i,
   output logic [127:0]            acc_o
);
   import iirbp_pkg::*;

   logic signed [32:0]  op_a;
   logic signed [32:0]  op_b;
   logic signed [65:0]  prod_in, prod_ff;
   logic [1:0]          amt_in, amt_ff;
   logic                sub_in, sub_ff;
   logic                valid_in, valid_ff;
   logic [127:0]        ext;
   logic [127:0]        acc_in, acc_ff;

   // halves: low halves are unsigned, high halves carry the sign
   always_comb begin
      op_a = ctrl_i.part[1] ? {coef_i[63], coef_i[63:32]} : {1'b0, coef_i[31:0]};
      op_b = ctrl_i.part[0] ? {data_i[63], data_i[63:32]} : {1'b0, data_i[31:0]};
      prod_in  = op_a * op_b;
      sub_in   = ctrl_i.sub;
      valid_in = ctrl_i.issue;
      case (ctrl_i.part)
         PART_LO_LO: amt_in = 2'd0;
         PART_LO_HI: amt_in = 2'd1;
         PART_HI_LO: amt_in = 2'd1;
         PART_HI_HI: amt_in = 2'd2;
         default:    amt_in = 2'd0;
      endcase
   end

   // align the registered partial and fold it into the accumulator
   always_comb begin
      case (amt_ff)
         2'd0:    ext = {{62{prod_ff[65]}}, prod_ff};
         2'd1:    ext = {{30{prod_ff[65]}}, prod_ff, 32'd0};
         2'd2:    ext = {prod_ff[63:0], 64'd0};
         default: ext = '0;
      endcase
      if (ctrl_i.clear) begin
         acc_in = '0;
      end else if (valid_ff) begin
         acc_in = sub_ff ? (acc_ff - ext) : (acc_ff + ext);
      end else begin
         acc_in = acc_ff;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      amt_ff  <= amt_in;
      sub_ff  <= sub_in;
      acc_ff  <= acc_in;
   end

   assign acc_o = acc_ff;

endmodule

>>> tb/sv/tb_iir_bandpass_cascade.sv
// self-checking testbench for the ecg band-pass cascade (high-pass then low-pass)
// depends on iirbp_pkg and iir_bandpass_cascade; predicts every output sample in 128-bit fixed point
module tb_iir_bandpass_cascade;
   import iirbp_pkg::*;

   localparam int N_ITEMS    = 1350;
   localparam int IO_SHIFT   = DEF_STATE_FRAC_BITS - 15;
   localparam int LATENCY    = 4 * (2 * DEF_HP_TAPS - 1) + 4 * (2 * DEF_LP_TAPS - 1) + 4;
   localparam int DRAIN      = 2 * LATENCY;
   localparam int HOLD_LEN   = 800;
   localparam int CYCLE_CAP  = 600000;
   localparam int QUIET_TAIL = 150;

   // section indexes of the predictor
   localparam int SEC_HP = 0;
   localparam int SEC_LP = 1;

   // directed stimulus row: result typed in only where it is obvious
   typedef struct packed {
      logic [15:0] sample;
      logic        known;
      logic [15:0] result;
   } vector_type;

   typedef enum int {SEG_NOISE, SEG_SQUARE, SEG_HOLD, SEG_WANDER} segment_kind_type;

   localparam int N_DIRECTED = 22;
   localparam vector_type DIRECTED [N_DIRECTED] = '{
      '{16'h0000, 1'b1, 16'h0000},   // zero history gives zero out
      '{16'h0000, 1'b1, 16'h0000},
      '{16'h0001, 1'b0, 16'h0000},   // smallest positive impulse
      '{16'h0000, 1'b0, 16'h0000},
      '{16'hFFFF, 1'b0, 16'h0000},   // smallest negative impulse
      '{16'h7FFF, 1'b0, 16'h0000},   // positive full scale
      '{16'h7FFF, 1'b0, 16'h0000},
      '{16'h7FFF, 1'b0, 16'h0000},
      '{16'h8000, 1'b0, 16'h0000},   // negative full scale
      '{16'h8000, 1'b0, 16'h0000},
      '{16'h8000, 1'b0, 16'h0000},
      '{16'h7FFF, 1'b0, 16'h0000},   // full-swing alternation
      '{16'h8000, 1'b0, 16'h0000},
      '{16'h5555, 1'b0, 16'h0000},
      '{16'hAAAA, 1'b0, 16'h0000},
      '{16'h0000, 1'b0, 16'h0000},
      '{16'h4000, 1'b0, 16'h0000},
      '{16'hC000, 1'b0, 16'h0000},
      '{16'h00FF, 1'b0, 16'h0000},
      '{16'hFF00, 1'b0, 16'h0000},
      '{16'h7FFE, 1'b0, 16'h0000},
      '{16'h8001, 1'b0, 16'h0000}
   };

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata  = '0;   // [15:0] sample_in
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;         // [15:0] sample_out

   // predictor state: coefficients and histories of both sections
   logic signed [63:0] coef_b [2][MAX_TAPS];
   logic signed [63:0] coef_a [2][MAX_TAPS];
   logic signed [63:0] in_hist  [2][MAX_TAPS];
   logic signed [63:0] out_hist [2][MAX_TAPS];
   int                 sec_taps [2];

   logic [15:0] filtered_q [$];
   logic [15:0] expected_sample;
   int          n_sent    = 0;
   int          n_results = 0;
   int          n_sat     = 0;
   int          n_fail    = 0;
   bit          gaps_on   = 1'b1;
   bit          hold_done = 1'b0;
   wire         quiet_tail = (n_sent >= N_ITEMS - QUIET_TAIL);

   iir_bandpass_cascade u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever begin
         #5 clock = ~clock;
      end
   end

   // decimal mant * 10^-dexp to fixed point, round half up on magnitude
   function automatic void set_coef(input int sec, input bit is_a, input int k,
                                    input bit neg, input logic [63:0] mant, input int dexp);
      logic [127:0] v;
      logic [127:0] pow10;
      logic [63:0]  mag;
      pow10 = 128'd1;
      for (int i = 0; i < dexp; i++) begin
         pow10 = pow10 * 128'd10;
      end
      v   = (128'(mant) << (DEF_COEF_FRAC_BITS + 1)) / pow10;
      v   = (v + 128'd1) >> 1;
      mag = (v > 128'h7FFF_FFFF_FFFF_FFFF) ? 64'h7FFF_FFFF_FFFF_FFFF : v[63:0];
      if (is_a) begin
         coef_a[sec][k] = neg ? -$signed(mag) : $signed(mag);
      end else begin
         coef_b[sec][k] = neg ? -$signed(mag) : $signed(mag);
      end
   endfunction

   // one direct form i section: shift in x, accumulate, floor shift, clamp to 64 bits
   function automatic logic signed [63:0] section_step(input int sec,
                                                       input logic signed [63:0] x);
      logic signed [127:0] acc;
      logic signed [127:0] wc;
      logic signed [127:0] wh;
      logic signed [127:0] sh;
      logic signed [63:0]  y;
      for (int k = sec_taps[sec] - 1; k > 0; k--) begin
         in_hist[sec][k] = in_hist[sec][k - 1];
      end
      in_hist[sec][0] = x;
      acc = '0;
      for (int k = 0; k < sec_taps[sec]; k++) begin
         wc  = coef_b[sec][k];
         wh  = in_hist[sec][k];
         acc = acc + wc * wh;
      end
      for (int k = 1; k < sec_taps[sec]; k++) begin
         wc  = coef_a[sec][k];
         wh  = out_hist[sec][k - 1];
         acc = acc - wc * wh;
      end
      sh = acc >>> DEF_COEF_FRAC_BITS;
      if (sh[127:63] != {65{sh[127]}}) begin
         y = sh[127] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
      end else begin
         y = sh[63:0];
      end
      for (int k = sec_taps[sec] - 2; k > 0; k--) begin
         out_hist[sec][k] = out_hist[sec][k - 1];
      end
      out_hist[sec][0] = y;
      return y;
   endfunction

   // full cascade for one input sample, output narrowed and clamped to q1.15
   function automatic logic [15:0] filtered_sample(input logic [15:0] s);
      logic signed [63:0] x;
      logic signed [63:0] h;
      logic signed [63:0] y;
      logic signed [63:0] r;
      x = $signed(s);
      x = x <<< IO_SHIFT;
      h = section_step(SEC_HP, x);
      y = section_step(SEC_LP, h);
      r = y >>> IO_SHIFT;
      if (r > 64'sd32767) begin
         return 16'h7FFF;
      end else if (r < -64'sd32768) begin
         return 16'h8000;
      end
      return r[15:0];
   endfunction

   // one input transaction, with an optional idle burst ahead of it
   task automatic send_sample(input logic [15:0] s, input bit known, input logic [15:0] typed);
      logic [15:0] p;
      if (gaps_on && !quiet_tail && $urandom_range(0, 3) == 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat ($urandom_range(0, 3)) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= s;
      do @(posedge clock); while (!req_tready);
      p = filtered_sample(s);
      filtered_q.push_back(known ? typed : p);
      n_sent++;
   endtask

   // random part: noise, square waves, holds and walks; full-scale square waves drive the output into clamping
   task automatic run_random();
      segment_kind_type kind;
      int               len;
      int               half;
      int               amp;
      int               level;
      int               v;
      bit               first;
      first = 1'b1;
      while (n_sent < N_ITEMS) begin
         kind    = first ? SEG_SQUARE : segment_kind_type'($urandom_range(0, 3));
         first   = 1'b0;
         gaps_on = ($urandom_range(0, 3) != 0);
         level   = $urandom_range(0, 65535) - 32768;
         case (kind)
            SEG_NOISE: begin
               len = $urandom_range(10, 60);
               for (int i = 0; i < len && n_sent < N_ITEMS; i++) begin
                  send_sample(16'($urandom), 1'b0, '0);
               end
            end
            SEG_SQUARE: begin
               half = $urandom_range(60, 220);
               amp  = $urandom_range(0, 1) ? 32767 : $urandom_range(8000, 32767);
               len  = half * $urandom_range(2, 4);
               for (int i = 0; i < len && n_sent < N_ITEMS; i++) begin
                  if ((i / half) % 2 == 0) begin
                     v = amp;
                  end else begin
                     v = (amp == 32767) ? -32768 : -amp;
                  end
                  send_sample(16'(v), 1'b0, '0);
               end
            end
            SEG_HOLD: begin
               len = $urandom_range(20, 120);
               for (int i = 0; i < len && n_sent < N_ITEMS; i++) begin
                  send_sample(16'(level), 1'b0, '0);
               end
            end
            default: begin
               // slow random walk with a little noise on top
               len = $urandom_range(50, 250);
               for (int i = 0; i < len && n_sent < N_ITEMS; i++) begin
                  level = level + $urandom_range(0, 1024) - 512;
                  if (level > 32767) level = 32767;
                  if (level < -32768) level = -32768;
                  v = level + $urandom_range(0, 64) - 32;
                  if (v > 32767) v = 32767;
                  if (v < -32768) v = -32768;
                  send_sample(16'(v), 1'b0, '0);
               end
            end
         endcase
      end
   endtask

   // result side: random stall bursts, one long hold-off, none in the tail
   initial begin
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         @(negedge clock);
         if (!hold_done && n_sent >= 200) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_LEN - 1) @(negedge clock);
            hold_done = 1'b1;
         end else if (gaps_on && !quiet_tail && $urandom_range(0, 4) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(0, 3)) @(negedge clock);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // compare each result transaction with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         n_results++;
         if (rsp_tdata == 16'h7FFF || rsp_tdata == 16'h8000) n_sat++;
         if (filtered_q.size() == 0) begin
            $error("sample_out: expected none, actual %0d", $signed(rsp_tdata));
            n_fail++;
         end else begin
            expected_sample = filtered_q.pop_front();
            if (rsp_tdata !== expected_sample) begin
               $error("sample_out: expected %0d, actual %0d",
                      $signed(expected_sample), $signed(rsp_tdata));
               n_fail++;
            end
         end
      end
   end

   // watchdog
   initial begin
      int cycles;
      cycles = 0;
      while (cycles < CYCLE_CAP) begin
         @(posedge clock);
         cycles++;
      end
      $display("tb_iir_bandpass_cascade NOT OK");
      $finish;
   end

   // main sequence
   initial begin
      int tail;
      sec_taps[SEC_HP] = DEF_HP_TAPS;
      sec_taps[SEC_LP] = DEF_LP_TAPS;
      for (int s = 0; s < 2; s++) begin
         for (int k = 0; k < MAX_TAPS; k++) begin
            coef_b[s][k]   = '0;
            coef_a[s][k]   = '0;
            in_hist[s][k]  = '0;
            out_hist[s][k] = '0;
         end
      end
      // high-pass section
      set_coef(SEC_HP, 0, 0, 0, 64'd9936059630099, 13);
      set_coef(SEC_HP, 0, 1, 1, 64'd496802981505,  11);
      set_coef(SEC_HP, 0, 2, 0, 64'd9936059630099, 12);
      set_coef(SEC_HP, 0, 3, 1, 64'd9936059630099, 12);
      set_coef(SEC_HP, 0, 4, 0, 64'd496802981505,  11);
      set_coef(SEC_HP, 0, 5, 1, 64'd9936059630099, 13);
      set_coef(SEC_HP, 1, 1, 1, 64'd4987170880032, 12);
      set_coef(SEC_HP, 1, 2, 0, 64'd994876577478,  11);
      set_coef(SEC_HP, 1, 3, 1, 64'd9923271718397, 12);
      set_coef(SEC_HP, 1, 4, 0, 64'd4948929633379, 12);
      set_coef(SEC_HP, 1, 5, 1, 64'd9872528097289, 13);
      // low-pass section
      set_coef(SEC_LP, 0, 0, 0, 64'd6594578622361, 23);
      set_coef(SEC_LP, 0, 1, 0, 64'd3956747173417, 22);
      set_coef(SEC_LP, 0, 2, 0, 64'd9891867933541, 22);
      set_coef(SEC_LP, 0, 3, 0, 64'd1318915724472, 21);
      set_coef(SEC_LP, 0, 4, 0, 64'd9891867933541, 22);
      set_coef(SEC_LP, 0, 5, 0, 64'd3956747173417, 22);
      set_coef(SEC_LP, 0, 6, 0, 64'd6594578622361, 23);
      set_coef(SEC_LP, 1, 1, 1, 64'd5842652126594, 12);
      set_coef(SEC_LP, 1, 2, 0, 64'd1422559205773, 11);
      set_coef(SEC_LP, 1, 3, 1, 64'd1847523699553, 11);
      set_coef(SEC_LP, 1, 4, 0, 64'd1349869991173, 11);
      set_coef(SEC_LP, 1, 5, 1, 64'd5260796021795, 12);
      set_coef(SEC_LP, 1, 6, 0, 64'd8543931786795, 13);

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed rows
      for (int i = 0; i < N_DIRECTED; i++) begin
         send_sample(DIRECTED[i].sample, DIRECTED[i].known, DIRECTED[i].result);
      end
      run_random();
      @(negedge clock);
      req_tvalid <= 1'b0;

      // wait for the pipeline to empty, then a little longer for strays
      while (filtered_q.size() != 0) @(posedge clock);
      tail = 0;
      while (tail < DRAIN) begin
         @(posedge clock);
         tail++;
      end

      $display("sent %0d samples (directed extremes, noise, square waves, holds, walks)",
               n_sent);
      $display("checked %0d filtered samples, %0d of them clamped to full scale",
               n_results, n_sat);
      if (n_fail == 0 && filtered_q.size() == 0) begin
         $display("tb_iir_bandpass_cascade OK");
      end else begin
         $display("tb_iir_bandpass_cascade NOT OK");
      end
      $finish;
   end

endmodule
